/* src/sik_pkg.sv */
// Shared types, widths and constants of the SCARA inverse-kinematics block.
// No dependencies; imported by every module of the block but sik_delay.
package sik_pkg;

    // Fraction bits of coordinates, lengths and scales
    localparam int FRAC_BITS = 16;

    // Datapath widths
    localparam int CW        = 52;  // CORDIC x/y lane
    localparam int ZW        = 34;  // CORDIC angle accumulator, Q30 radians
    localparam int DEN_W     = 63;  // elbow cosine denominator
    localparam int Q_W       = 30;  // cosine quotient bits
    localparam int SQ_VW     = 61;  // sqrt radicand
    localparam int SQ_RW     = 62;  // sqrt partial root

    // Step counts of the divider and square-root rows
    localparam int DIV_STEPS  = 30;
    localparam int SQRT_STEPS = 31;

    // Q30 constants
    localparam logic [63:0]          ONE_Q30     = 64'd1 << 30;
    localparam logic signed [ZW-1:0] HALF_PI_Q30 = 34'sd1686629713;

    // Configuration register indexes
    localparam logic [2:0] REG_INNER_LEN    = 3'd0;
    localparam logic [2:0] REG_OUTER_LEN    = 3'd1;
    localparam logic [2:0] REG_TOWER_OFF_X  = 3'd2;
    localparam logic [2:0] REG_TOWER_OFF_Y  = 3'd3;
    localparam logic [2:0] REG_SCALE_X      = 3'd4;
    localparam logic [2:0] REG_SCALE_Y      = 3'd5;
    localparam logic [2:0] REG_RIGHT_HANDED = 3'd6;

    // Elementary rotation angle of one CORDIC step, Q30 radians
    function automatic logic [31:0] atan_step(input int idx);
        logic [31:0] v;
        case (idx)
            0:       v = 32'd843314857;
            1:       v = 32'd497837830;
            2:       v = 32'd263043837;
            3:       v = 32'd133525159;
            4:       v = 32'd67021687;
            5:       v = 32'd33543516;
            6:       v = 32'd16775851;
            7:       v = 32'd8388437;
            8:       v = 32'd4194283;
            9:       v = 32'd2097149;
            10:      v = 32'd1048576;
            default: v = 32'(ONE_Q30 >> idx);
        endcase
        return v;
    endfunction

endpackage

/* src/sik_delay.sv */
// Enabled shift line that carries side data alongside the arithmetic rows.
// No package dependencies.
module sik_delay #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1
) (
    input  logic             clk,
    input  logic             en,
    input  logic [WIDTH-1:0] d,
    output logic [WIDTH-1:0] q
);

    logic [WIDTH-1:0] tap_reg [DEPTH];

    // Advance every tap when the pipeline moves
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tap_reg[0] <= d;
            for (int i = 1; i < DEPTH; i++)
            begin
                tap_reg[i] <= tap_reg[i-1];
            end
        end
    end

    assign q = tap_reg[DEPTH-1];

endmodule

/* src/sik_div_cell.sv */
// One restoring-division cell: one quotient bit of the elbow cosine.
// Depends on sik_pkg for widths.
module sik_div_cell (
    input  logic                      clk,
    input  logic                      en,
    input  logic [sik_pkg::DEN_W-1:0] den,
    input  logic [sik_pkg::DEN_W-1:0] r_in,
    input  logic [sik_pkg::Q_W-1:0]   q_in,
    output logic [sik_pkg::DEN_W-1:0] r_out,
    output logic [sik_pkg::Q_W-1:0]   q_out
);
    import sik_pkg::*;

    logic [DEN_W:0]   r2;
    logic             ge;
    logic [DEN_W-1:0] r_next;

    // Shift remainder, subtract divisor where it fits
    always_comb
    begin
        r2 = {r_in, 1'b0};
        ge = (r2 >= {1'b0, den});
        if (ge)
        begin
            r_next = DEN_W'(r2 - {1'b0, den});
        end
        else
        begin
            r_next = r2[DEN_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_out <= r_next;
            q_out <= {q_in[Q_W-2:0], ge};
        end
    end

endmodule

/* src/sik_sqrt_cell.sv */
// One digit cell of the integer square root; BIT_EXP is the trial bit position.
// Depends on sik_pkg for widths.
module sik_sqrt_cell #(
    parameter int BIT_EXP = 0
) (
    input  logic                      clk,
    input  logic                      en,
    input  logic [sik_pkg::SQ_VW-1:0] v_in,
    input  logic [sik_pkg::SQ_RW-1:0] res_in,
    output logic [sik_pkg::SQ_VW-1:0] v_out,
    output logic [sik_pkg::SQ_RW-1:0] res_out
);
    import sik_pkg::*;

    localparam logic [SQ_RW-1:0] TRIAL_BIT = SQ_RW'(1) << BIT_EXP;

    logic [SQ_RW:0]   trial;
    logic [SQ_VW-1:0] v_next;
    logic [SQ_RW-1:0] res_next;

    // Take the trial subtraction where the radicand allows it
    always_comb
    begin
        trial = {1'b0, res_in} + {1'b0, TRIAL_BIT};
        if ({2'b00, v_in} >= trial)
        begin
            v_next   = SQ_VW'({2'b00, v_in} - trial);
            res_next = (res_in >> 1) + TRIAL_BIT;
        end
        else
        begin
            v_next   = v_in;
            res_next = res_in >> 1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            v_out   <= v_next;
            res_out <= res_next;
        end
    end

endmodule

/* src/sik_cordic_cell.sv */
// One vectoring CORDIC cell: rotates (x, y) towards the x axis by step STEP.
// Depends on sik_pkg for widths and the elementary angle table.
module sik_cordic_cell #(
    parameter int STEP = 0
) (
    input  logic                          clk,
    input  logic                          en,
    input  logic signed [sik_pkg::CW-1:0] x_in,
    input  logic signed [sik_pkg::CW-1:0] y_in,
    input  logic signed [sik_pkg::ZW-1:0] z_in,
    output logic signed [sik_pkg::CW-1:0] x_out,
    output logic signed [sik_pkg::ZW-1:0] z_out,
    output logic signed [sik_pkg::CW-1:0] y_out
);
    import sik_pkg::*;

    localparam logic signed [ZW-1:0] ANGLE = ZW'(atan_step(STEP));

    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;
    logic signed [CW-1:0] x_next;
    logic signed [CW-1:0] y_next;
    logic signed [ZW-1:0] z_next;

    // Rotate by the sign of y, accumulate the angle
    always_comb
    begin
        dx = y_in >>> STEP;
        dy = x_in >>> STEP;
        if (!y_in[CW-1])
        begin
            x_next = x_in + dx;
            y_next = y_in - dy;
            z_next = z_in + ANGLE;
        end
        else
        begin
            x_next = x_in - dx;
            y_next = y_in + dy;
            z_next = z_in - ANGLE;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_out <= x_next;
            y_out <= y_next;
            z_out <= z_next;
        end
    end

endmodule

/* src/scara_inverse_kinematics.sv */
// Top level of the SCARA two-link inverse-kinematics pipeline.
// Depends on sik_pkg, sik_delay, sik_div_cell, sik_sqrt_cell, sik_cordic_cell.

// Takes one target point (x, y, z) per clock, unless the output stalls, and returns
// shoulder and elbow angles in signed Q10.16 degrees, z unchanged, and a flag when
// the point lies out of reach. The datapath is one pipeline: input scaling, squared
// radius, a row of 30 division cells for the elbow cosine, a row of 31 square-root
// cells for its sine, and three rows of CORDIC_ITERATIONS vectoring cells side by
// side; one item enters every cycle while the output does not stall. The whole
// pipeline holds while a result waits at the output. Configuration writes are to be
// made only while no item is in flight; the block itself does not enforce this.
module scara_inverse_kinematics #(
    parameter int CORDIC_ITERATIONS = 24
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [31:0] target_x,
    input  logic signed [31:0] target_y,
    input  logic signed [31:0] target_z,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [25:0] shoulder_angle,
    output logic signed [25:0] elbow_angle,
    output logic signed [31:0] lift_position,
    output logic               unreachable
);
    import sik_pkg::*;

    localparam int N        = CORDIC_ITERATIONS;
    localparam int ST_PX    = 2;
    localparam int ST_DIVIN = 7;
    localparam int ST_C     = ST_DIVIN + DIV_STEPS + 1;
    localparam int ST_V     = ST_C + 2;
    localparam int ST_S     = ST_V + SQRT_STEPS;
    localparam int ST_AB    = ST_S + 2;
    localparam int ST_PRE   = ST_AB + 1;
    localparam int ST_CORD  = ST_PRE + N;
    localparam int ST_DEGM  = ST_CORD + 2;

    localparam logic signed [31:0]  DEG_PER_RAD = 32'sd961263669;
    localparam logic signed [65:0]  DEG_ROUND   = 66'sd1 <<< 37;
    localparam logic signed [27:0]  ANGLE_LIMIT = 28'sd23592960;
    localparam logic [SQ_VW-1:0]    ONE_Q60     = SQ_VW'(1) << 60;

    // ------------------------------------------------------------------
    // Configuration registers
    logic [30:0]        inner_len_reg;
    logic [30:0]        outer_len_reg;
    logic signed [31:0] tower_off_x_reg;
    logic signed [31:0] tower_off_y_reg;
    logic [30:0]        scale_x_reg;
    logic [30:0]        scale_y_reg;
    logic               right_handed_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inner_len_reg    <= 31'd9830400;
            outer_len_reg    <= 31'd9830400;
            tower_off_x_reg  <= 32'sd6553600;
            tower_off_y_reg  <= -32'sd3932160;
            scale_x_reg      <= 31'd65536;
            scale_y_reg      <= 31'd65536;
            right_handed_reg <= 1'b1;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_INNER_LEN:    inner_len_reg    <= cfg_data[30:0];
                REG_OUTER_LEN:    outer_len_reg    <= cfg_data[30:0];
                REG_TOWER_OFF_X:  tower_off_x_reg  <= cfg_data;
                REG_TOWER_OFF_Y:  tower_off_y_reg  <= cfg_data;
                REG_SCALE_X:      scale_x_reg      <= cfg_data[30:0];
                REG_SCALE_Y:      scale_y_reg      <= cfg_data[30:0];
                REG_RIGHT_HANDED: right_handed_reg <= cfg_data[0];
                default:          ;
            endcase
        end
    end

    // Derive squared lengths and the cosine denominator from the registers
    logic [61:0]       l11_reg;
    logic [61:0]       l22_reg;
    logic [61:0]       l12_reg;
    logic [62:0]       lsq_reg;
    logic [DEN_W-1:0]  den_reg;

    always_ff @(posedge clk)
    begin
        l11_reg <= inner_len_reg * inner_len_reg;
        l22_reg <= outer_len_reg * outer_len_reg;
        l12_reg <= inner_len_reg * outer_len_reg;
        lsq_reg <= {1'b0, l11_reg} + {1'b0, l22_reg};
        den_reg <= {l12_reg, 1'b0};
    end

    // ------------------------------------------------------------------
    // Flow control: the whole pipeline moves together
    logic                en;
    logic [ST_DEGM:1]    vld_reg;
    logic                out_valid_reg;

    assign en        = out_ready || !out_valid_reg;
    assign in_ready  = en;
    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg       <= {vld_reg[ST_DEGM-1:1], in_valid};
            out_valid_reg <= vld_reg[ST_DEGM];
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: scale the target
    logic signed [63:0] prodx_reg;
    logic signed [63:0] prody_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prodx_reg <= target_x * $signed({1'b0, scale_x_reg});
            prody_reg <= target_y * $signed({1'b0, scale_y_reg});
        end
    end

    // Stage 2: drop fraction, subtract tower offset
    logic signed [63:0] pxw;
    logic signed [63:0] pyw;
    logic signed [47:0] px_reg;
    logic signed [47:0] py_reg;

    always_comb
    begin
        pxw = (prodx_reg >>> FRAC_BITS) - 64'(tower_off_x_reg);
        pyw = (prody_reg >>> FRAC_BITS) - 64'(tower_off_y_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            px_reg <= pxw[47:0];
            py_reg <= pyw[47:0];
        end
    end

    // Stage 3: partial products of the squares
    logic [46:0] ux;
    logic [46:0] uy;
    logic [63:0] xll_reg;
    logic [63:0] yll_reg;
    logic [46:0] xhl_reg;
    logic [46:0] yhl_reg;
    logic [29:0] xhh_reg;
    logic [29:0] yhh_reg;

    always_comb
    begin
        ux = px_reg[47] ? 47'(-px_reg) : px_reg[46:0];
        uy = py_reg[47] ? 47'(-py_reg) : py_reg[46:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            xll_reg <= ux[31:0] * ux[31:0];
            yll_reg <= uy[31:0] * uy[31:0];
            xhl_reg <= ux[46:32] * ux[31:0];
            yhl_reg <= uy[46:32] * uy[31:0];
            xhh_reg <= ux[46:32] * ux[46:32];
            yhh_reg <= uy[46:32] * uy[46:32];
        end
    end

    // Stage 4: assemble the squares
    logic [95:0] xsq_reg;
    logic [95:0] ysq_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            xsq_reg <= (96'(xhh_reg) << 64) + (96'(xhl_reg) << 33) + 96'(xll_reg);
            ysq_reg <= (96'(yhh_reg) << 64) + (96'(yhl_reg) << 33) + 96'(yll_reg);
        end
    end

    // Stage 5: squared radius
    logic [95:0] ssum_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ssum_reg <= xsq_reg + ysq_reg;
        end
    end

    // Stage 6: numerator magnitude and sign
    logic [96:0] diff;
    logic [95:0] mag_reg;
    logic        neg_reg;

    assign diff = {1'b0, ssum_reg} - {34'd0, lsq_reg};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            neg_reg <= diff[96];
            mag_reg <= diff[96] ? 96'(-diff) : diff[95:0];
        end
    end

    // Stage 7: range checks, divider entry
    logic             unr7_reg;
    logic             eq7_reg;
    logic             neg7_reg;
    logic [DEN_W-1:0] rem7_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            unr7_reg <= mag_reg > {33'd0, den_reg};
            eq7_reg  <= mag_reg == {33'd0, den_reg};
            neg7_reg <= neg_reg;
            rem7_reg <= mag_reg[DEN_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Division row: one quotient bit per cell
    logic [DEN_W-1:0] dr [DIV_STEPS+1];
    logic [Q_W-1:0]   dq [DIV_STEPS+1];

    assign dr[0] = rem7_reg;
    assign dq[0] = '0;

    for (genvar k = 0; k < DIV_STEPS; k++)
    begin : g_div
        sik_div_cell u_div (
            .clk   (clk),
            .en    (en),
            .den   (den_reg),
            .r_in  (dr[k]),
            .q_in  (dq[k]),
            .r_out (dr[k+1]),
            .q_out (dq[k+1])
        );
    end

    logic [2:0] flg_div;

    sik_delay #(.WIDTH(3), .DEPTH(DIV_STEPS)) u_flg_div (
        .clk (clk),
        .en  (en),
        .d   ({neg7_reg, eq7_reg, unr7_reg}),
        .q   (flg_div)
    );

    // Cosine stage: clamp and apply sign
    logic [30:0]        cmag;
    logic signed [31:0] c_reg;
    logic               unr_c_reg;

    assign cmag = (flg_div[0] || flg_div[1]) ? 31'(ONE_Q30) : {1'b0, dq[DIV_STEPS]};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_reg     <= flg_div[2] ? -$signed(32'(cmag)) : $signed(32'(cmag));
            unr_c_reg <= flg_div[0];
        end
    end

    // Square the cosine, then form 1 - C^2
    logic signed [63:0] csq_full;
    logic [SQ_VW-1:0]   csq_reg;
    logic [SQ_VW-1:0]   v_reg;

    assign csq_full = c_reg * c_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            csq_reg <= csq_full[SQ_VW-1:0];
            v_reg   <= ONE_Q60 - csq_reg;
        end
    end

    // Square-root row: one root bit per cell
    logic [SQ_VW-1:0] sv [SQRT_STEPS+1];
    logic [SQ_RW-1:0] sr [SQRT_STEPS+1];

    assign sv[0] = v_reg;
    assign sr[0] = '0;

    for (genvar k = 0; k < SQRT_STEPS; k++)
    begin : g_sqrt
        sik_sqrt_cell #(.BIT_EXP(60 - 2 * k)) u_sqrt (
            .clk     (clk),
            .en      (en),
            .v_in    (sv[k]),
            .res_in  (sr[k]),
            .v_out   (sv[k+1]),
            .res_out (sr[k+1])
        );
    end

    // Carry cosine beside the root
    logic [31:0] c_s;

    sik_delay #(.WIDTH(32), .DEPTH(ST_S - ST_C)) u_c_sq (
        .clk (clk),
        .en  (en),
        .d   (c_reg),
        .q   (c_s)
    );

    // Products of the outer length with sine and cosine
    logic [61:0]        pa_reg;
    logic signed [63:0] pb_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pa_reg <= outer_len_reg * sr[SQRT_STEPS][30:0];
            pb_reg <= $signed(c_s) * $signed({1'b0, outer_len_reg});
        end
    end

    // Second atan2 operands
    logic signed [63:0]   bw;
    logic signed [CW-1:0] a_reg;
    logic signed [CW-1:0] b_reg;

    assign bw = $signed(64'({inner_len_reg, 14'd0})) + (pb_reg >>> 16);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_reg <= CW'(pa_reg[61:16]);
            b_reg <= CW'(bw);
        end
    end

    // Sine and cosine alongside the product stages
    logic [62:0] sc_ab;

    sik_delay #(.WIDTH(63), .DEPTH(ST_AB - ST_S)) u_sc_ab (
        .clk (clk),
        .en  (en),
        .d   ({sr[SQRT_STEPS][30:0], c_s}),
        .q   (sc_ab)
    );

    // Arm coordinates carried to the CORDIC entry
    logic [95:0] pxy_ab;

    sik_delay #(.WIDTH(96), .DEPTH(ST_AB - ST_PX)) u_pxy_ab (
        .clk (clk),
        .en  (en),
        .d   ({py_reg, px_reg}),
        .q   (pxy_ab)
    );

    // ------------------------------------------------------------------
    // CORDIC entry: quadrant fold and zero detection for the three lanes
    logic signed [CW-1:0] lx [3];
    logic signed [CW-1:0] ly [3];
    logic signed [CW-1:0] cx [3][N+1];
    logic signed [CW-1:0] cy [3][N+1];
    logic signed [ZW-1:0] cz [3][N+1];
    logic signed [CW-1:0] pre_x_reg [3];
    logic signed [CW-1:0] pre_y_reg [3];
    logic signed [ZW-1:0] pre_z_reg [3];
    logic [2:0]           zero_reg;
    logic [2:0]           zero_d;

    always_comb
    begin
        lx[0] = CW'($signed(pxy_ab[47:0]));
        ly[0] = CW'($signed(pxy_ab[95:48]));
        lx[1] = b_reg;
        ly[1] = a_reg;
        lx[2] = CW'($signed(sc_ab[31:0]));
        ly[2] = CW'($signed({1'b0, sc_ab[62:32]}));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int l = 0; l < 3; l++)
            begin
                zero_reg[l] <= (lx[l] == '0) && (ly[l] == '0);
                if (lx[l][CW-1] && !ly[l][CW-1])
                begin
                    pre_x_reg[l] <= ly[l];
                    pre_y_reg[l] <= -lx[l];
                    pre_z_reg[l] <= HALF_PI_Q30;
                end
                else if (lx[l][CW-1])
                begin
                    pre_x_reg[l] <= -ly[l];
                    pre_y_reg[l] <= lx[l];
                    pre_z_reg[l] <= -HALF_PI_Q30;
                end
                else
                begin
                    pre_x_reg[l] <= lx[l];
                    pre_y_reg[l] <= ly[l];
                    pre_z_reg[l] <= '0;
                end
            end
        end
    end

    // Three rows of CORDIC cells
    for (genvar l = 0; l < 3; l++)
    begin : g_lane
        assign cx[l][0] = pre_x_reg[l];
        assign cy[l][0] = pre_y_reg[l];
        assign cz[l][0] = pre_z_reg[l];
        for (genvar k = 0; k < N; k++)
        begin : g_step
            sik_cordic_cell #(.STEP(k)) u_cordic (
                .clk   (clk),
                .en    (en),
                .x_in  (cx[l][k]),
                .y_in  (cy[l][k]),
                .z_in  (cz[l][k]),
                .x_out (cx[l][k+1]),
                .z_out (cz[l][k+1]),
                .y_out (cy[l][k+1])
            );
        end
    end

    sik_delay #(.WIDTH(3), .DEPTH(N)) u_zero (
        .clk (clk),
        .en  (en),
        .d   (zero_reg),
        .q   (zero_d)
    );

    // Shoulder difference and elbow angle in radians
    logic signed [ZW-1:0] za [3];
    logic signed [ZW-1:0] sh_rad_reg;
    logic signed [ZW-1:0] el_rad_reg;

    always_comb
    begin
        for (int l = 0; l < 3; l++)
        begin
            za[l] = zero_d[l] ? '0 : cz[l][N];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sh_rad_reg <= za[0] - za[1];
            el_rad_reg <= za[2];
        end
    end

    // Scale to degrees
    logic signed [65:0] sh_mul_reg;
    logic signed [65:0] el_mul_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sh_mul_reg <= sh_rad_reg * DEG_PER_RAD;
            el_mul_reg <= el_rad_reg * DEG_PER_RAD;
        end
    end

    // Round half up, saturate to the angle range
    function automatic logic signed [25:0] to_deg(input logic signed [65:0] p);
        logic signed [65:0] t;
        logic signed [27:0] d;
        t = (p + DEG_ROUND) >>> 38;
        d = t[27:0];
        if (d > ANGLE_LIMIT)
        begin
            d = ANGLE_LIMIT;
        end
        else if (d < -ANGLE_LIMIT)
        begin
            d = -ANGLE_LIMIT;
        end
        return d[25:0];
    endfunction

    logic [31:0] tz_d;
    logic        unr_d;

    sik_delay #(.WIDTH(32), .DEPTH(ST_DEGM)) u_tz (
        .clk (clk),
        .en  (en),
        .d   (target_z),
        .q   (tz_d)
    );

    sik_delay #(.WIDTH(1), .DEPTH(ST_DEGM - ST_C)) u_unr (
        .clk (clk),
        .en  (en),
        .d   (unr_c_reg),
        .q   (unr_d)
    );

    // Output register: mirror angles for a left-handed arm
    logic signed [25:0] sh_deg;
    logic signed [25:0] el_deg;
    logic signed [25:0] shoulder_reg;
    logic signed [25:0] elbow_reg;
    logic signed [31:0] lift_reg;
    logic               unr_out_reg;

    assign sh_deg = to_deg(sh_mul_reg);
    assign el_deg = to_deg(el_mul_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            shoulder_reg <= right_handed_reg ? sh_deg : -sh_deg;
            elbow_reg    <= right_handed_reg ? el_deg : -el_deg;
            lift_reg     <= tz_d;
            unr_out_reg  <= unr_d;
        end
    end

    assign shoulder_angle = shoulder_reg;
    assign elbow_angle    = elbow_reg;
    assign lift_position  = lift_reg;
    assign unreachable    = unr_out_reg;

    // ------------------------------------------------------------------
    // Assertions
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(vld_reg))
        else $error("pipeline valid bits moved during a stall");

    a_elbow_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (elbow_angle <= 26'sd23592960) && (elbow_angle >= -26'sd23592960))
        else $error("elbow angle outside saturation range");

    a_elbow_sign: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && right_handed_reg |-> !elbow_angle[25])
        else $error("right-handed elbow angle is negative");

endmodule

/* verif/ik_checker.sv */
// Checker of the SCARA inverse-kinematics block: tracks its registers,
// predicts each pose and compares it with the block's output.
// Depends on sik_pkg for the register indexes and the Q30 quarter turn.
`timescale 1ns / 1ps

module ik_checker #(
    parameter int CORDIC_ITERATIONS = 24
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic signed [31:0] target_x,
    input  logic signed [31:0] target_y,
    input  logic signed [31:0] target_z,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic signed [25:0] shoulder_angle,
    input  logic signed [25:0] elbow_angle,
    input  logic signed [31:0] lift_position,
    input  logic               unreachable,
    output int                 errors,
    output int                 pending
);
    import sik_pkg::*;

    typedef struct packed {
        logic signed [25:0] shoulder;
        logic signed [25:0] elbow;
        logic signed [31:0] lift;
        logic               unreach;
    } arm_pose_t;

    localparam longint ONE_Q30     = 64'sd1 << 30;
    localparam longint DEG_PER_RAD = 64'sd961263669;
    localparam longint ANGLE_MAX   = 64'sd23592960;
    localparam longint ROT_ANGLE [11] = '{843314857, 497837830, 263043837, 133525159,
        67021687, 33543516, 16775851, 8388437, 4194283, 2097149, 1048576};

    // Register copies of the block
    longint inner_len, outer_len, scl_x, scl_y, off_x, off_y;
    bit     right_hand;

    arm_pose_t pose_q[$];

    assign pending = pose_q.size();

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned root, b;
        root = 0;
        b = 64'd1 << 62;
        while (b > v)
            b >>= 2;
        while (b != 0)
        begin
            if (v >= root + b)
            begin
                v    = v - (root + b);
                root = (root >> 1) + b;
            end
            else
                root >>= 1;
            b >>= 2;
        end
        return root;
    endfunction

    // Vectoring CORDIC: angle of (x, y) in Q30 radians
    function automatic longint vector_angle(longint y, longint x);
        longint ang, t, dx, dy, rot;
        ang = 0;
        if (x == 0 && y == 0)
            return 0;
        if (x < 0)
        begin
            t = x;
            if (y >= 0)
            begin
                x = y; y = -t; ang = longint'(HALF_PI_Q30);
            end
            else
            begin
                x = -y; y = t; ang = -longint'(HALF_PI_Q30);
            end
        end
        for (int i = 0; i < CORDIC_ITERATIONS && i < 32; i++)
        begin
            dx  = y >>> i;
            dy  = x >>> i;
            rot = (i < 11) ? ROT_ANGLE[i] : (ONE_Q30 >>> i);
            if (y >= 0)
            begin
                x += dx; y -= dy; ang += rot;
            end
            else
            begin
                x -= dx; y += dy; ang -= rot;
            end
        end
        return ang;
    endfunction

    function automatic longint rad_to_deg(longint rad);
        longint d;
        d = (rad * DEG_PER_RAD + (64'sd1 <<< 37)) >>> 38;
        if (d > ANGLE_MAX)
            d = ANGLE_MAX;
        if (d < -ANGLE_MAX)
            d = -ANGLE_MAX;
        return d;
    endfunction

    function automatic arm_pose_t predict_pose(logic signed [31:0] tx, logic signed [31:0] ty,
                                               logic signed [31:0] tz);
        arm_pose_t       p;
        longint          px, py, c, s, a, b, sh, el;
        longint unsigned ux, uy;
        logic [127:0]    sq, lsq, den, m;
        bit              neg;
        px  = ((longint'(tx) * scl_x) >>> 16) - off_x;
        py  = ((longint'(ty) * scl_y) >>> 16) - off_y;
        ux  = (px < 0) ? -px : px;
        uy  = (py < 0) ? -py : py;
        sq  = 128'(ux) * 128'(ux) + 128'(uy) * 128'(uy);
        lsq = 128'(inner_len) * 128'(inner_len) + 128'(outer_len) * 128'(outer_len);
        den = 128'(2) * 128'(inner_len) * 128'(outer_len);
        neg = sq < lsq;
        m   = neg ? lsq - sq : sq - lsq;
        p.unreach = 1'b0;
        // Clamp the elbow cosine when the point is out of reach
        if (m > den)
        begin
            p.unreach = 1'b1;
            c = ONE_Q30;
        end
        else if (m == den)
            c = ONE_Q30;
        else
            c = longint'((m << 30) / den);
        if (neg)
            c = -c;
        s  = longint'(int_sqrt((64'd1 << 60) - 64'(c * c)));
        a  = longint'((64'(outer_len) * 64'(s)) >> 16);
        b  = (inner_len <<< 14) + ((outer_len * c) >>> 16);
        sh = rad_to_deg(vector_angle(py, px) - vector_angle(a, b));
        el = rad_to_deg(vector_angle(s, c));
        if (!right_hand)
        begin
            sh = -sh;
            el = -el;
        end
        p.shoulder = sh[25:0];
        p.elbow    = el[25:0];
        p.lift     = tz;
        return p;
    endfunction

    // Track registers, queue predictions, compare results
    always @(posedge clk or negedge rst_n)
    begin
        arm_pose_t want, got;
        if (!rst_n)
        begin
            inner_len  = 9830400;
            outer_len  = 9830400;
            off_x      = 6553600;
            off_y      = -3932160;
            scl_x      = 65536;
            scl_y      = 65536;
            right_hand = 1'b1;
            errors     = 0;
            pose_q.delete();
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_INNER_LEN:    inner_len  = longint'(cfg_data[30:0]);
                    REG_OUTER_LEN:    outer_len  = longint'(cfg_data[30:0]);
                    REG_TOWER_OFF_X:  off_x      = longint'($signed(cfg_data));
                    REG_TOWER_OFF_Y:  off_y      = longint'($signed(cfg_data));
                    REG_SCALE_X:      scl_x      = longint'(cfg_data[30:0]);
                    REG_SCALE_Y:      scl_y      = longint'(cfg_data[30:0]);
                    REG_RIGHT_HANDED: right_hand = cfg_data[0];
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
                pose_q.push_back(predict_pose(target_x, target_y, target_z));
            if (out_valid && out_ready)
            begin
                got = '{shoulder_angle, elbow_angle, lift_position, unreachable};
                if (pose_q.size() == 0)
                begin
                    $display("%0t: pose with none expected: sh %0d el %0d z %0d unr %0b",
                             $time, got.shoulder, got.elbow, got.lift, got.unreach);
                    errors++;
                end
                else
                begin
                    want = pose_q.pop_front();
                    if (got.shoulder !== want.shoulder)
                        $display("%0t: shoulder expected %0d got %0d",
                                 $time, want.shoulder, got.shoulder);
                    if (got.elbow !== want.elbow)
                        $display("%0t: elbow expected %0d got %0d",
                                 $time, want.elbow, got.elbow);
                    if (got.lift !== want.lift)
                        $display("%0t: lift expected %0d got %0d",
                                 $time, want.lift, got.lift);
                    if (got.unreach !== want.unreach)
                        $display("%0t: unreachable expected %0b got %0b",
                                 $time, want.unreach, got.unreach);
                    if (got !== want)
                        errors++;
                end
            end
        end
    end

endmodule

/* verif/tb_scara_inverse_kinematics.sv */
// Testbench top of the SCARA inverse-kinematics block: clock, reset,
// register writes, target stimulus and verdict. Depends on sik_pkg, scara_inverse_kinematics and ik_checker.
`timescale 1ns / 1ps

module tb_scara_inverse_kinematics;
    import sik_pkg::*;

    localparam logic [2:0] REG_UNUSED = 3'd7;
    localparam int         HOLD_CYCLES = 500;
    localparam int         STALL_LIMIT = 4000;
    localparam int         DRAIN_CYCLES = 150;
    localparam longint     MM = 65536;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_write = 1'b0;
    logic [2:0]         cfg_index = '0;
    logic [31:0]        cfg_data = '0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic signed [31:0] target_x = '0;
    logic signed [31:0] target_y = '0;
    logic signed [31:0] target_z = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic signed [25:0] shoulder_angle;
    logic signed [25:0] elbow_angle;
    logic signed [31:0] lift_position;
    logic               unreachable;
    int                 errors;
    int                 pending;

    bit     idle_on = 1'b1;
    bit     hold_req = 1'b0;
    int     stall_cycles = 0;
    longint arm_l1 = 9830400, arm_l2 = 9830400;
    longint arm_ox = 6553600, arm_oy = -3932160;
    longint arm_sx = 65536, arm_sy = 65536;

    scara_inverse_kinematics uut (.*);

    ik_checker chk (.*);

    initial
    begin
        forever #4 clk = ~clk;
    end

    // Receiver: random stalls, plus one long hold-off on request
    initial
    begin
        @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            else
            begin
                out_ready <= !(idle_on && $urandom_range(99) < 23);
                @(posedge clk);
            end
        end
    end

    // Watchdog on cycles with no item moving
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("FAIL scara_inverse_kinematics");
            $finish;
        end
    end

    task automatic send_point(longint x, longint y, longint z);
        while (idle_on && $urandom_range(99) < 23)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        target_x <= x[31:0];
        target_y <= y[31:0];
        target_z <= z[31:0];
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    task automatic write_reg(logic [2:0] idx, longint val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val[31:0];
        @(posedge clk);
    endtask

    // Drop valid and wait until every pose is back and the pipe is empty
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_arm(longint l1, longint l2, longint ox, longint oy,
                           longint sx, longint sy, bit rh);
        arm_l1 = l1; arm_l2 = l2; arm_ox = ox; arm_oy = oy; arm_sx = sx; arm_sy = sy;
        write_reg(REG_INNER_LEN, l1);
        write_reg(REG_OUTER_LEN, l2);
        write_reg(REG_TOWER_OFF_X, ox);
        write_reg(REG_TOWER_OFF_Y, oy);
        write_reg(REG_SCALE_X, sx);
        write_reg(REG_SCALE_Y, sy);
        write_reg(REG_RIGHT_HANDED, longint'(rh));
        write_reg(REG_UNUSED, longint'($urandom));
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    // Mostly points around the arm's reach, the rest any 32-bit value
    function automatic longint pick_coord(longint off, longint scl);
        longint          reach, span, d;
        longint unsigned r;
        if ($urandom_range(99) < 30 || scl == 0)
            return longint'($signed($urandom));
        reach = (arm_l1 + arm_l2) >>> 16;
        span  = reach + reach / 4 + 1;
        r     = {$urandom, $urandom};
        d     = longint'(r % longint'(2 * span + 1)) - span;
        return (((d <<< 16) + off) <<< 16) / scl;
    endfunction

    initial
    begin
        longint l2;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset geometry, L1 = L2 = 150 mm
        send_point(0, 0, 0);
        send_point(arm_ox, arm_oy, 32'sh7fffffff);
        send_point(arm_ox + 2 * arm_l1, arm_oy, -64'sd2147483648);
        send_point(arm_ox + 2 * arm_l1 + 1, arm_oy, 1);
        send_point(arm_ox - 2 * arm_l1, arm_oy, -1);
        send_point(arm_ox, arm_oy + 2 * arm_l1, 5);
        send_point(arm_ox, arm_oy - 2 * arm_l1, 6);
        send_point(arm_ox - 100 * MM, arm_oy, 7);
        send_point(arm_ox - 100 * MM, arm_oy - 10 * MM, 8);
        send_point(arm_ox + arm_l1, arm_oy + arm_l1, 9);
        send_point(arm_ox - arm_l1, arm_oy - arm_l1, 10);
        send_point(arm_ox + 50 * MM, arm_oy + 80 * MM, 11);
        send_point(32'sh7fffffff, 32'sh7fffffff, 12);
        send_point(-64'sd2147483648, -64'sd2147483648, 13);
        send_point(32'sh7fffffff, -64'sd2147483648, 14);
        send_point(-64'sd2147483648, 32'sh7fffffff, 15);
        send_point(arm_ox, arm_oy + 1, 16);
        send_point(arm_ox + 1, arm_oy, 17);
        drain();

        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph)
                0: set_arm(200 * MM, 120 * MM, 80 * MM, -40 * MM, 65536, 65536, 1'b1);
                1: set_arm(150 * MM, 150 * MM, 100 * MM, 0, 65536, 65536, 1'b0);
                2: set_arm(0, 150 * MM, 20 * MM, 0, 65536, 0, 1'b1);
                3: set_arm(64'h7fffffff, 64'h7fffffff, -64'sd2147483648,
                           -64'sd2147483648, 64'h7fffffff, 64'h7fffffff, 1'b0);
                4: set_arm(1, 1, 64'h7fffffff, 64'h7fffffff, 0, 65536, 1'b1);
                default:
                    set_arm(longint'($urandom_range(50, 400)) * MM,
                            longint'($urandom_range(50, 400)) * MM,
                            longint'($signed($urandom_range(0, 400))) * MM - 200 * MM,
                            longint'($signed($urandom_range(0, 400))) * MM - 200 * MM,
                            longint'($urandom_range(60000, 70000)),
                            longint'($urandom_range(60000, 70000)),
                            1'($urandom));
            endcase
            // Phase 0 fills the pipe against a stopped receiver, phase 1 runs without gaps
            hold_req = (ph == 0);
            idle_on  = (ph != 1);
            if (ph == 2)
            begin
                // Zero inner arm with the point exactly at the outer length
                l2 = arm_l2;
                send_point(arm_ox + l2, 0, 3);
                send_point(arm_ox - l2, 0, 4);
            end
            repeat (150)
                send_point(pick_coord(arm_ox, arm_sx), pick_coord(arm_oy, arm_sy),
                           longint'($signed($urandom)));
            drain();
            idle_on = 1'b1;
        end

        if (errors == 0 && pending == 0)
            $display("PASS scara_inverse_kinematics");
        else
            $display("FAIL scara_inverse_kinematics");
        $finish;
    end

endmodule
